// ===== src/lfzv_pkg.sv =====
// ----------------------------------------------------------------------------
// lfzv_pkg: shared types and constants of the log frame varint encoder
// Holds the slot classification, the queue item format and frame constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lfzv_pkg;

    localparam int unsigned SLOT_W     = 6;
    localparam int unsigned FIXED_W    = 40;
    localparam int unsigned RAW_W      = 32;
    localparam int unsigned OPND_W     = FIXED_W + 1;
    localparam int unsigned SCALE_W    = 11;
    localparam int unsigned PROD_W     = OPND_W + SCALE_W;
    localparam int unsigned THR_W      = 11;

    localparam logic [SLOT_W-1:0]  SLOT_COUNT    = 6'd42;
    localparam logic [7:0]         MARKER_BYTE   = 8'h49;
    localparam logic [SCALE_W-1:0] SCALE_GYRO    = 11'd10;
    localparam logic [SCALE_W-1:0] SCALE_UNIT    = 11'd1;
    localparam logic [SCALE_W-1:0] SCALE_PID     = 11'd1000;
    localparam logic [SCALE_W-1:0] SCALE_RC      = 11'd500;
    localparam logic [SCALE_W-1:0] MOTOR_SPAN    = 11'd1999;
    localparam logic [RAW_W-1:0]   MOTOR_BASE    = 32'd48;
    localparam logic [RAW_W-1:0]   THROTTLE_BASE = 32'd1000;
    localparam logic [RAW_W-1:0]   SCHEMA_ID     = 32'd1;

    // Entries of the item queue between front and back.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    // How a slot turns into its emitted value.
    localparam logic [2:0] K_RAW   = 3'd0;  // value_raw, held iteration or schema id, unsigned
    localparam logic [2:0] K_QUANT = 3'd1;  // scaled and rounded, zigzagged
    localparam logic [2:0] K_MOTOR = 3'd2;  // motor mapping, zigzagged
    localparam logic [2:0] K_THROT = 3'd3;  // quantized throttle, also held
    localparam logic [2:0] K_THR31 = 3'd4;  // held throttle plus base

    // Range check applied to the fixed-point operand.
    localparam logic [1:0] R_NONE = 2'd0;
    localparam logic [1:0] R_UNIT = 2'd1;   // 0 <= x <= 1
    localparam logic [1:0] R_SYM  = 2'd2;   // -1 <= x <= 1

    typedef struct packed {
        logic [2:0]         kind;
        logic [SCALE_W-1:0] scale;
        logic               chk_fin;
        logic [1:0]         rng;
        logic               marker;
        logic               frame_end;
        logic               frame_start;
    } t_cls;

    typedef struct packed {
        logic [RAW_W-1:0] uval;
        logic             marker;
        logic             bad;
    } t_qitem;

endpackage

`default_nettype wire

// ===== src/log_frame_zigzag_varint_encoder.sv =====
// ----------------------------------------------------------------------------
// log_frame_zigzag_varint_encoder: flight log frame field encoder
// The slave stream takes one frame field per item, slots 0 to 41 in order.
// Each field is quantized or derived, zigzag mapped where signed, and sent
// out as little-endian base-128 varint bytes, one byte per master item, with
// an 'I' marker byte ahead of slot 0. tlast marks the final byte of a field;
// tuser is set on the final byte of slot 41 when any field of the frame
// failed its checks. Slots 42 to 63 are dropped without output.
// The first byte of a field passes the operand, product, queue, serializer
// and output registers after its item is taken. Bytes leave at one per
// cycle while the master side is ready; a field is one to five bytes, plus
// the marker for slot 0. The serializer sets the pace; a four-entry
// queue lets the quantizer keep taking items while bytes drain.
// When the master side stalls, the output byte holds and the queue fills;
// the slave side then stalls once the pipeline behind it is full.
// Reset clears the held setpoint, gyro, throttle and iteration values, the
// frame error flag, the queue and all valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module log_frame_zigzag_varint_encoder
    import lfzv_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // value_fixed[39:0], value_raw[71:40]
    input  wire logic [6:0]  s_axis_tuser,  // slot[5:0], value_finite[6]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // out_byte[7:0]
    output logic             m_axis_tlast,
    output logic [0:0]       m_axis_tuser   // frame_bad[0]
);

    logic   push, full, q_valid, pop, bad;
    t_qitem push_item, q_item;

    lfzv_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_slot   (s_axis_tuser[5:0]),
        .i_fixed  (s_axis_tdata[39:0]),
        .i_raw    (s_axis_tdata[71:40]),
        .i_finite (s_axis_tuser[6]),
        .o_push   (push),
        .o_item   (push_item),
        .i_full   (full)
    );

    lfzv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    lfzv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_last    (m_axis_tlast),
        .o_bad     (bad)
    );

    assign m_axis_tuser[0] = bad;

endmodule

`default_nettype wire

// ===== src/lfzv_front.sv =====
// ----------------------------------------------------------------------------
// lfzv_front: slot classification and quantization pipeline
// Takes field items, keeps the held frame state, scales and rounds the value
// in two registered stages and pushes the value to emit into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lfzv_front
    import lfzv_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [SLOT_W-1:0]  i_slot,
    input  wire logic [FIXED_W-1:0] i_fixed,
    input  wire logic [RAW_W-1:0]   i_raw,
    input  wire logic               i_finite,
    output logic                    o_push,
    output t_qitem                  o_item,
    input  wire logic               i_full
);

    localparam logic signed [OPND_W-1:0] ONE     = OPND_W'(1) <<< FRAC_BITS;
    localparam logic        [PROD_W:0]   HALF    = (PROD_W+1)'(1) << (FRAC_BITS - 1);
    localparam logic        [PROD_W:0]   POS_MAX = (PROD_W+1)'(32'h7FFF_FFFF);
    localparam logic        [PROD_W:0]   NEG_MAX = (PROD_W+1)'(32'h8000_0000);

    // Held frame state.
    logic [FIXED_W-1:0] r_held_sp [3];
    logic [FIXED_W-1:0] r_held_gy [3];
    logic [RAW_W-1:0]   r_held_iter;
    logic [THR_W-1:0]   r_held_thr;
    logic               r_err;

    // Stage 1: operand.
    logic                     r_s1_v;
    logic signed [OPND_W-1:0] r_s1_x;
    logic [RAW_W-1:0]         r_s1_raw;
    logic                     r_s1_fin;
    t_cls                     r_s1_cls;

    // Stage 2: product.
    logic              r_s2_v;
    logic [PROD_W-1:0] r_s2_prod;
    logic              r_s2_neg;
    logic              r_s2_pos;
    logic              r_s2_pre_ok;
    logic [RAW_W-1:0]  r_s2_raw;
    t_cls              r_s2_cls;

    logic accept, s1_move, s2_move, slot_ok;
    t_cls cls;
    logic signed [OPND_W-1:0] opnd;
    logic [RAW_W-1:0]         raw_eff;
    logic [1:0]               ax;

    assign s2_move = r_s2_v && !i_full;
    assign s1_move = r_s1_v && (!r_s2_v || s2_move);
    assign o_ready = !r_s1_v || s1_move;
    assign accept  = i_valid && o_ready;
    assign slot_ok = i_slot < SLOT_COUNT;
    assign ax      = i_slot[1:0];

    always_comb begin
        cls = '{kind: K_QUANT, scale: SCALE_UNIT, chk_fin: 1'b1, rng: R_NONE,
                marker: 1'b0, frame_end: 1'b0, frame_start: 1'b0};
        case (i_slot) inside
            6'd0: begin
                cls.kind        = K_RAW;
                cls.marker      = 1'b1;
                cls.frame_start = 1'b1;
            end
            6'd1, [6'd35:6'd40]: cls.kind = K_RAW;
            6'd41: begin
                cls.kind      = K_RAW;
                cls.frame_end = 1'b1;
            end
            [6'd2:6'd7]:   cls.scale = SCALE_GYRO;
            [6'd8:6'd10]:  cls.scale = SCALE_UNIT;
            6'd11: begin
                cls.kind  = K_THROT;
                cls.scale = SCALE_PID;
                cls.rng   = R_UNIT;
            end
            [6'd12:6'd23]: cls.scale = SCALE_PID;
            [6'd24:6'd27]: begin
                cls.kind  = K_MOTOR;
                cls.scale = MOTOR_SPAN;
                cls.rng   = R_UNIT;
            end
            [6'd28:6'd30]: begin
                cls.scale = SCALE_RC;
                cls.rng   = R_SYM;
            end
            6'd31: begin
                cls.kind    = K_THR31;
                cls.chk_fin = 1'b0;
            end
            [6'd32:6'd34]: cls.chk_fin = 1'b0;
            default: cls.kind = K_RAW;
        endcase
    end

    // Setpoint minus gyro for the derived error slots, else the input value.
    always_comb begin
        if (i_slot >= 6'd32 && i_slot <= 6'd34) begin
            opnd = $signed({r_held_sp[ax][FIXED_W-1], r_held_sp[ax]})
                 - $signed({r_held_gy[ax][FIXED_W-1], r_held_gy[ax]});
        end else begin
            opnd = $signed({i_fixed[FIXED_W-1], i_fixed});
        end
        if (i_slot == 6'd40) begin
            raw_eff = r_held_iter;
        end else if (i_slot == 6'd41) begin
            raw_eff = SCHEMA_ID;
        end else begin
            raw_eff = i_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_held_sp[k] <= '0;
                r_held_gy[k] <= '0;
            end
            r_held_iter <= '0;
        end else if (accept && slot_ok) begin
            if (i_slot == 6'd0) begin
                r_held_iter <= i_raw;
            end
            if (i_slot >= 6'd2 && i_slot <= 6'd4) begin
                r_held_gy[2'(i_slot - 6'd2)] <= i_fixed;
            end
            if (i_slot >= 6'd8 && i_slot <= 6'd10) begin
                r_held_sp[2'(i_slot - 6'd8)] <= i_fixed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (o_ready) begin
            r_s1_v <= accept && slot_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x   <= opnd;
            r_s1_raw <= raw_eff;
            r_s1_fin <= i_finite;
            r_s1_cls <= cls;
        end
    end

    // Stage 1 to 2: magnitude times scale, and the input checks.
    logic              neg;
    logic [OPND_W-1:0] mag;
    logic              rng_ok;

    assign neg = r_s1_x[OPND_W-1];
    assign mag = neg ? OPND_W'(-r_s1_x) : OPND_W'(r_s1_x);

    always_comb begin
        case (r_s1_cls.rng)
            R_UNIT:  rng_ok = !neg && r_s1_x <= ONE;
            R_SYM:   rng_ok = r_s1_x >= -ONE && r_s1_x <= ONE;
            default: rng_ok = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (!r_s2_v || s2_move) begin
            r_s2_v <= s1_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_prod   <= PROD_W'(mag) * PROD_W'(r_s1_cls.scale);
            r_s2_neg    <= neg;
            r_s2_pos    <= !neg && (r_s1_x != '0);
            r_s2_pre_ok <= (r_s1_fin || !r_s1_cls.chk_fin) && rng_ok;
            r_s2_raw    <= r_s1_raw;
            r_s2_cls    <= r_s1_cls;
        end
    end

    // Stage 2: round half away from zero, range check, zigzag.
    logic [PROD_W:0]  q;
    logic             ovf;
    logic [RAW_W-1:0] qs;
    logic [RAW_W-1:0] sval;
    logic             ok;
    logic             err_next;

    assign q   = ((PROD_W+1)'(r_s2_prod) + HALF) >> FRAC_BITS;
    assign ovf = r_s2_neg ? (q > NEG_MAX) : (q > POS_MAX);
    assign qs  = r_s2_neg ? RAW_W'(-q[RAW_W-1:0]) : q[RAW_W-1:0];

    always_comb begin
        ok   = 1'b1;
        sval = '0;
        case (r_s2_cls.kind)
            K_RAW: begin
                ok = 1'b1;
            end
            K_THR31: begin
                sval = THROTTLE_BASE + RAW_W'(r_held_thr);
            end
            K_MOTOR: begin
                ok = r_s2_pre_ok;
                if (ok && r_s2_pos) begin
                    sval = MOTOR_BASE + RAW_W'(r_s2_prod >> FRAC_BITS);
                end
            end
            default: begin
                ok   = r_s2_pre_ok && !ovf;
                sval = ok ? qs : '0;
            end
        endcase
    end

    assign err_next = (r_err && !r_s2_cls.frame_start) || !ok;

    always_comb begin
        o_item.marker = r_s2_cls.marker;
        o_item.bad    = r_s2_cls.frame_end && err_next;
        if (r_s2_cls.kind == K_RAW) begin
            o_item.uval = r_s2_raw;
        end else begin
            o_item.uval = {sval[RAW_W-2:0], 1'b0} ^ {RAW_W{sval[RAW_W-1]}};
        end
    end

    assign o_push = s2_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err      <= 1'b0;
            r_held_thr <= '0;
        end else if (s2_move) begin
            r_err <= r_s2_cls.frame_end ? 1'b0 : err_next;
            if (r_s2_cls.kind == K_THROT) begin
                r_held_thr <= ok ? qs[THR_W-1:0] : '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/lfzv_queue.sv =====
// ----------------------------------------------------------------------------
// lfzv_queue: short item queue between front and back
// A small register queue that lets front and back stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module lfzv_queue
    import lfzv_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_qitem    i_item,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_qitem    o_item
);

    t_qitem             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wr;
    logic [Q_AW-1:0]    r_rd;
    logic [Q_AW:0]      r_cnt;

    assign o_full  = r_cnt == (Q_AW+1)'(Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/lfzv_back.sv =====
// ----------------------------------------------------------------------------
// lfzv_back: varint byte serializer
// Pops one value at a time and emits the marker and base-128 bytes, one per
// cycle while the output register is free, through a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module lfzv_back
    import lfzv_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  t_qitem    i_q_item,
    output logic      o_q_pop,
    output logic      o_valid,
    input  wire logic i_ready,
    output logic [7:0] o_byte,
    output logic      o_last,
    output logic      o_bad
);

    logic             r_busy;
    logic [RAW_W-1:0] r_val;
    logic             r_mark;
    logic             r_bad;
    logic             r_ovalid;
    logic [7:0]       r_obyte;
    logic             r_olast;
    logic             r_obad;

    logic       out_free, emit, more, done, load;
    logic [7:0] byte_n;

    assign out_free = !r_ovalid || i_ready;
    assign emit     = r_busy && out_free;
    assign more     = |r_val[RAW_W-1:7];
    assign done     = emit && !r_mark && !more;
    assign load     = i_q_valid && (!r_busy || done);
    assign o_q_pop  = load;
    assign byte_n   = r_mark ? MARKER_BYTE : {more, r_val[6:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_val  <= i_q_item.uval;
            r_mark <= i_q_item.marker;
            r_bad  <= i_q_item.bad;
        end else if (emit) begin
            if (r_mark) begin
                r_mark <= 1'b0;
            end else begin
                r_val <= r_val >> 7;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_obyte <= byte_n;
            r_olast <= !r_mark && !more;
            r_obad  <= !r_mark && !more && r_bad;
        end
    end

    assign o_valid = r_ovalid;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;
    assign o_bad   = r_obad;

endmodule

`default_nettype wire
